/* rtl/awpid_pkg.sv */
package awpid_pkg;

  // Field and state widths
  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CFG_W   = 16;

  // Operand and product widths of the gain multipliers
  localparam int unsigned OP_P_W  = ERR_W + 1;           // e - e1
  localparam int unsigned OP_D_W  = ERR_W + 2;           // e - 2*e1 + e2
  localparam int unsigned I_SPLIT = 20;                  // low slice of the integral operand
  localparam int unsigned I_HI_W  = SUM_W - I_SPLIT;
  localparam int unsigned PP_W    = GAIN_W + OP_P_W;
  localparam int unsigned PD_W    = GAIN_W + OP_D_W;
  localparam int unsigned PIL_W   = GAIN_W + I_SPLIT + 1;
  localparam int unsigned PIH_W   = GAIN_W + I_HI_W;
  localparam int unsigned TOTAL_W = 58;                  // positional sum peaks near 2^54

  // Angle wrap: one turn is 360 * 256 = 45 * 2^11
  localparam int unsigned DIFF_W    = 26;
  localparam int unsigned TURN_LO_W = 11;
  localparam int unsigned TURN_HI_W = DIFF_W - TURN_LO_W;
  localparam int unsigned REM_HI_W  = 6;
  localparam int unsigned QUOT_W    = 9;
  localparam int unsigned RECIP_W   = 16;
  localparam int unsigned RECIP_SHIFT = 21;

  localparam logic [ERR_W-1:0]     TURN_Q8      = 17'd92160;
  localparam logic [ERR_W-1:0]     HALF_TURN_Q8 = 17'd46080;
  localparam logic [TURN_HI_W-1:0] TURN_HI      = 15'd45;
  // 183 turns: keeps the offset difference positive; odd, so it flips quotient parity
  localparam logic [DIFF_W-1:0]    DIFF_OFFSET  = 26'd16865280;
  // ceil(2^21 / 45): exact floor quotient for every 15-bit dividend
  localparam logic [RECIP_W-1:0]   RECIP        = 16'd46604;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 17'sd46080;
  localparam logic signed [ERR_W-1:0] ERR_MIN = -17'sd46080;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_GAIN_P = 2'd1,
    CFG_GAIN_I = 2'd2,
    CFG_GAIN_D = 2'd3
  } cfg_index_t;

  // Pipeline control handed to the wrap stages
  typedef struct packed {
    logic advance;   // whole pipeline moves this cycle
    logic load;      // an input beat enters stage one
  } pipe_ctl_t;

endpackage

/* rtl/angle_wrapped_pid_unit.sv */
// PID controller on a wrapped angle error, one sample per input beat.
// Input beat: target and measured angle, degrees times 256. Output beat: the
// drive value (accumulator integer part, truncated toward zero) and a flag
// set when the accumulator or the positional error sum clipped on that sample.
// The gains and the mode are set through the cfg port; the user must write them
// only while idle; the unit does not enforce this. They are not double-buffered.
// Pipeline: an accepted input beat passes through 3 wrap stages, an operand
// stage, a multiply stage, a partial-sum stage, the accumulator stage and the
// output register before its result beat is presented.
// Throughput: one beat per cycle while not stalled; each stage holds at most one
// sample and the only feedback paths (error history, error sum, accumulator)
// close in one stage. When the receiver stalls with a result held, the whole
// pipeline freezes and s_axis_tready drops in the same cycle; no beat is dropped.
// Reset (synchronous) clears the gains, the mode (positional), the error
// history, the error sum, the accumulator and every valid bit.
module angle_wrapped_pid_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] target_angle, [47:24] measured_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] drive
  output logic        m_axis_tuser,   // [0] saturated
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [awpid_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned TW = awpid_pkg::TOTAL_W;

  // Configuration
  logic                                 mode_incremental;
  logic signed [awpid_pkg::GAIN_W-1:0]  gain_p;
  logic signed [awpid_pkg::GAIN_W-1:0]  gain_i;
  logic signed [awpid_pkg::GAIN_W-1:0]  gain_d;

  // Controller state
  logic signed [awpid_pkg::ERR_W-1:0]   last_err;
  logic signed [awpid_pkg::ERR_W-1:0]   prev_err;
  logic signed [awpid_pkg::SUM_W-1:0]   err_sum;
  logic signed [awpid_pkg::ACC_W-1:0]   accum;

  // Pipeline
  logic                                 advance;
  awpid_pkg::pipe_ctl_t                 wrap_ctl;
  logic                                 err_valid;
  logic signed [awpid_pkg::ERR_W-1:0]   err;

  logic                                 s4_valid;
  logic                                 s4_sat;
  logic signed [awpid_pkg::OP_P_W-1:0]  op_p;
  logic signed [awpid_pkg::OP_D_W-1:0]  op_d;
  logic signed [awpid_pkg::OP_P_W-1:0]  op_p_next;
  logic signed [awpid_pkg::OP_D_W-1:0]  op_d_next;
  logic signed [awpid_pkg::SUM_W:0]     sum_wide;
  logic signed [awpid_pkg::SUM_W-1:0]   err_sum_next;
  logic                                 sum_hit;

  logic signed [awpid_pkg::SUM_W-1:0]   op_i;
  logic                                 s5_valid;
  logic                                 s5_sat;
  logic signed [awpid_pkg::PP_W-1:0]    prod_p;
  logic signed [awpid_pkg::PD_W-1:0]    prod_d;
  logic signed [awpid_pkg::PIL_W-1:0]   prod_il;
  logic signed [awpid_pkg::PIH_W-1:0]   prod_ih;

  logic                                 s6_valid;
  logic                                 s6_sat;
  logic signed [TW-1:0]                 part_a;
  logic signed [TW-1:0]                 part_b;

  logic signed [TW-1:0]                 total;
  logic signed [awpid_pkg::ACC_W-1:0]   accum_next;
  logic                                 acc_hit;
  logic                                 s7_valid;
  logic                                 s7_sat;

  logic signed [awpid_pkg::DRIVE_W-1:0] drive_floor;
  logic signed [awpid_pkg::DRIVE_W-1:0] drive_next;

  // Whole pipeline moves unless a result is held by the receiver
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign wrap_ctl      = '{advance: advance, load: s_axis_tvalid};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_incremental <= 1'b0;
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
    end else if (cfg_wr_en) begin
      unique case (awpid_pkg::cfg_index_t'(cfg_index))
        awpid_pkg::CFG_MODE:   mode_incremental <= cfg_wdata[0];
        awpid_pkg::CFG_GAIN_P: gain_p           <= signed'(cfg_wdata);
        awpid_pkg::CFG_GAIN_I: gain_i           <= signed'(cfg_wdata);
        awpid_pkg::CFG_GAIN_D: gain_d           <= signed'(cfg_wdata);
      endcase
    end
  end

  // Wrapped error
  awpid_wrap u_wrap (
    .clk            (clk),
    .rst            (rst),
    .ctl            (wrap_ctl),
    .target_angle   (signed'(s_axis_tdata[23:0])),
    .measured_angle (signed'(s_axis_tdata[47:24])),
    .err_valid      (err_valid),
    .err            (err)
  );

  // Operand stage: error differences and the saturating error sum
  assign sum_wide = (awpid_pkg::SUM_W + 1)'(err_sum) + (awpid_pkg::SUM_W + 1)'(err);
  assign sum_hit  = sum_wide[awpid_pkg::SUM_W] != sum_wide[awpid_pkg::SUM_W-1];

  always_comb begin
    if (!sum_hit) begin
      err_sum_next = sum_wide[awpid_pkg::SUM_W-1:0];
    end else if (sum_wide[awpid_pkg::SUM_W]) begin
      err_sum_next = awpid_pkg::SUM_MIN;
    end else begin
      err_sum_next = awpid_pkg::SUM_MAX;
    end
  end

  always_comb begin
    if (mode_incremental) begin
      op_p_next = awpid_pkg::OP_P_W'(err) - awpid_pkg::OP_P_W'(last_err);
      op_d_next = awpid_pkg::OP_D_W'(err) - (awpid_pkg::OP_D_W'(last_err) <<< 1)
                + awpid_pkg::OP_D_W'(prev_err);
    end else begin
      op_p_next = awpid_pkg::OP_P_W'(err);
      op_d_next = awpid_pkg::OP_D_W'(err) - awpid_pkg::OP_D_W'(last_err);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      last_err <= '0;
      prev_err <= '0;
      err_sum  <= '0;
    end else if (advance) begin
      s4_valid <= err_valid;
      if (err_valid) begin
        last_err <= err;
        if (mode_incremental) begin
          prev_err <= last_err;
        end else begin
          err_sum <= err_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_p   <= op_p_next;
      op_d   <= op_d_next;
      s4_sat <= !mode_incremental && sum_hit;
    end
  end

  // Multiply stage: the integral operand is split into two slices
  assign op_i = mode_incremental ? awpid_pkg::SUM_W'(last_err) : err_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (advance) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_sat  <= s4_sat;
      prod_p  <= awpid_pkg::PP_W'(gain_p) * awpid_pkg::PP_W'(op_p);
      prod_d  <= awpid_pkg::PD_W'(gain_d) * awpid_pkg::PD_W'(op_d);
      prod_il <= awpid_pkg::PIL_W'(gain_i)
               * awpid_pkg::PIL_W'(signed'({1'b0, op_i[awpid_pkg::I_SPLIT-1:0]}));
      prod_ih <= awpid_pkg::PIH_W'(gain_i)
               * awpid_pkg::PIH_W'(signed'(op_i[awpid_pkg::SUM_W-1:awpid_pkg::I_SPLIT]));
    end
  end

  // Partial sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (advance) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_sat <= s5_sat;
      part_a <= TW'(prod_p) + TW'(prod_d) + TW'(prod_il);
      part_b <= TW'(prod_ih) <<< awpid_pkg::I_SPLIT;
    end
  end

  // Accumulator stage: add onto the accumulator or replace it, then clip
  assign total = part_a + part_b + (mode_incremental ? TW'(accum) : TW'(0));

  always_comb begin
    acc_hit    = 1'b0;
    accum_next = total[awpid_pkg::ACC_W-1:0];
    if (total > TW'(awpid_pkg::ACC_MAX)) begin
      acc_hit    = 1'b1;
      accum_next = awpid_pkg::ACC_MAX;
    end else if (total < TW'(awpid_pkg::ACC_MIN)) begin
      acc_hit    = 1'b1;
      accum_next = awpid_pkg::ACC_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
      accum    <= '0;
    end else if (advance) begin
      s7_valid <= s6_valid;
      if (s6_valid) begin
        accum <= accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s7_sat <= s6_sat || acc_hit;
    end
  end

  // Output register: integer part, truncated toward zero
  assign drive_floor = accum[awpid_pkg::ACC_W-1:awpid_pkg::FRAC_W];
  assign drive_next  = (accum[awpid_pkg::ACC_W-1] && (|accum[awpid_pkg::FRAC_W-1:0]))
                     ? drive_floor + awpid_pkg::DRIVE_W'(1) : drive_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= drive_next;
      m_axis_tuser <= s7_sat;
    end
  end

  // Reset leaves no result beat pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat pending after reset");

  // A stall freezes the controller state
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(accum) && $stable(err_sum) && $stable(last_err)))
    else $error("controller state moved during a stall");

  // In incremental form a clip flag means the accumulator sits at a bound
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (s7_valid && s7_sat && mode_incremental)
      |-> (accum == awpid_pkg::ACC_MAX || accum == awpid_pkg::ACC_MIN))
    else $error("clip flag without accumulator at a bound");

endmodule

/* rtl/awpid_wrap.sv */
// Three-stage angle error wrap: offset difference, quotient by one turn,
// remainder folded into [-180, 180] degrees with ties to the even quotient.
module awpid_wrap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  awpid_pkg::pipe_ctl_t                  ctl,
  input  logic signed [awpid_pkg::ANGLE_W-1:0]  target_angle,
  input  logic signed [awpid_pkg::ANGLE_W-1:0]  measured_angle,
  output logic                                  err_valid,
  output logic signed [awpid_pkg::ERR_W-1:0]    err
);

  logic                                 s1_valid;
  logic [awpid_pkg::DIFF_W-1:0]         s1_diff;
  logic [awpid_pkg::DIFF_W-1:0]         diff_next;
  logic                                 s2_valid;
  logic [awpid_pkg::DIFF_W-1:0]         s2_diff;
  logic [awpid_pkg::QUOT_W-1:0]         s2_quot;
  logic [awpid_pkg::TURN_HI_W-1:0]      s1_hi;
  logic [awpid_pkg::TURN_HI_W+awpid_pkg::RECIP_W-1:0] quot_prod;
  logic [awpid_pkg::TURN_HI_W-1:0]      quot_turns;
  logic [awpid_pkg::TURN_HI_W-1:0]      rem_hi_wide;
  logic [awpid_pkg::ERR_W-1:0]          rem;
  logic                                 quot_even;
  logic [awpid_pkg::ERR_W-1:0]          err_next;

  // Offset difference, always positive
  assign diff_next = awpid_pkg::DIFF_W'(target_angle) - awpid_pkg::DIFF_W'(measured_angle)
                   + awpid_pkg::DIFF_OFFSET;

  // Quotient of the upper bits by 45 through the reciprocal
  assign s1_hi     = s1_diff[awpid_pkg::DIFF_W-1:awpid_pkg::TURN_LO_W];
  assign quot_prod = (awpid_pkg::TURN_HI_W + awpid_pkg::RECIP_W)'(s1_hi)
                   * (awpid_pkg::TURN_HI_W + awpid_pkg::RECIP_W)'(awpid_pkg::RECIP);

  // Remainder by one turn, then fold to the nearest multiple
  assign quot_turns  = awpid_pkg::TURN_HI_W'(s2_quot) * awpid_pkg::TURN_HI;
  assign rem_hi_wide = s2_diff[awpid_pkg::DIFF_W-1:awpid_pkg::TURN_LO_W] - quot_turns;
  assign rem         = {rem_hi_wide[awpid_pkg::REM_HI_W-1:0],
                        s2_diff[awpid_pkg::TURN_LO_W-1:0]};
  // the offset adds an odd count of turns, so an odd stored quotient is even
  assign quot_even   = s2_quot[0];

  always_comb begin
    if (rem > awpid_pkg::HALF_TURN_Q8) begin
      err_next = rem - awpid_pkg::TURN_Q8;
    end else if (rem < awpid_pkg::HALF_TURN_Q8) begin
      err_next = rem;
    end else if (quot_even) begin
      err_next = rem;
    end else begin
      err_next = rem - awpid_pkg::TURN_Q8;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      err_valid <= 1'b0;
    end else if (ctl.advance) begin
      s1_valid  <= ctl.load;
      s2_valid  <= s1_valid;
      err_valid <= s2_valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      s1_diff <= diff_next;
      s2_diff <= s1_diff;
      s2_quot <= quot_prod[awpid_pkg::RECIP_SHIFT +: awpid_pkg::QUOT_W];
      err     <= signed'(err_next);
    end
  end

  // Wrapped error stays within half a turn
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    err_valid |-> (err <= awpid_pkg::ERR_MAX && err >= awpid_pkg::ERR_MIN))
    else $error("wrapped error outside half a turn");

endmodule
